FILE: rtl/mersenne_twister_prng_assert.svh
// assertion macros for the mersenne twister generator
// depends on nothing; taken in by mt_datapath, which checks its own logic
`ifndef MERSENNE_TWISTER_PRNG_ASSERT_SVH
`define MERSENNE_TWISTER_PRNG_ASSERT_SVH

// same-cycle implication
`define MT_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define MT_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: rtl/mt_pkg.sv
// shared constants, codes and control structs of the mersenne twister generator
// depends on nothing
package mt_pkg;

  localparam int TABLE_WORDS = 624;
  localparam int SHIFT_DIST  = 397;
  localparam int ADDR_W      = $clog2(TABLE_WORDS);
  localparam int WORD_W      = 32;
  localparam int OP_W        = 2;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_WORDS - 1);
  localparam logic [ADDR_W:0]   TABLE_LEN = (ADDR_W + 1)'(TABLE_WORDS);
  localparam logic [ADDR_W:0]   SHIFT_LEN = (ADDR_W + 1)'(SHIFT_DIST);

  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h80000000;
  localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc60000;

  localparam logic [OP_W-1:0] OP_SEED  = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_K,
    RD_TWIST,
    RD_POS
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SEED,
    WR_INIT,
    WR_TWIST,
    WR_REQ
  } wr_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    k_clr;
    logic    k_inc;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    ld_hold;
    logic    mul;
    logic    ld_out;
  } mt_ctl_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] op;
    logic            pos_nz;
    logic            k_last;
    logic            out_busy;
  } mt_stat_t;

endpackage

FILE: rtl/mt_if.sv
// request and result channel interfaces of the mersenne twister generator
// depends on mt_pkg
interface mt_in_if import mt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] seed_or_word;
  logic [ADDR_W-1:0] word_index;

  modport source (output valid, op, seed_or_word, word_index, input ready);
  modport sink   (input valid, op, seed_or_word, word_index, output ready);
endinterface

interface mt_out_if import mt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

FILE: rtl/mt_ram.sv
// generic ram, one write port and two registered read ports with enables
// depends on nothing
module mt_ram #(
  parameter int DEPTH = 624,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/mt_datapath.sv
// datapath: request latch, index counter, seed multiplier, twist and temper logic,
// state table and result register; depends on mt_pkg, mt_ram and the assertion header
`include "mersenne_twister_prng_assert.svh"

module mt_datapath import mt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mt_ctl_t           ctl,
  input  logic              in_valid,
  input  logic [OP_W-1:0]   in_op,
  input  logic [WORD_W-1:0] in_seed_or_word,
  input  logic [ADDR_W-1:0] in_word_index,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_random_value,
  output mt_stat_t          stat
);

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] val_r;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [WORD_W-1:0] hold_r, hold_nxt;
  logic [WORD_W-1:0] prod_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic              re_a, re_b;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [WORD_W-1:0] rdata_a, rdata_b;

  logic              in_fire;
  logic              k_last;
  logic              out_busy;
  logic              out_load;
  logic [ADDR_W-1:0] k_next_addr;
  logic [ADDR_W:0]   far_sum;
  logic [ADDR_W-1:0] far_addr;
  logic [WORD_W-1:0] hold_mixed;
  logic [WORD_W-1:0] init_word;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] twist_word;

  assign in_fire     = in_valid & ctl.in_ready;
  assign k_last      = (k_r == LAST_ADDR);
  assign out_busy    = out_valid_r & ~out_ready;
  assign out_load    = ctl.ld_out & ~out_busy;
  assign k_next_addr = k_last ? '0 : k_r + 1'b1;
  assign far_sum     = {1'b0, k_r} + SHIFT_LEN;
  assign far_addr    = (far_sum >= TABLE_LEN) ? ADDR_W'(far_sum - TABLE_LEN)
                                              : far_sum[ADDR_W-1:0];
  assign hold_mixed  = hold_r ^ (hold_r >> 30);
  assign init_word   = prod_r + {{(WORD_W - ADDR_W){1'b0}}, k_r};
  assign mix         = (hold_r & UPPER_BIT) | (rdata_a & LOWER_BITS);
  assign twist_word  = rdata_b ^ (mix >> 1) ^ (mix[0] ? TWIST_XOR : '0);

  always_comb begin
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = k_r;
    raddr_b = far_addr;
    unique case (ctl.rd)
      RD_NONE:  ;
      RD_K:     re_a = 1'b1;
      RD_TWIST: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = k_next_addr;
      end
      RD_POS: begin
        re_a    = 1'b1;
        raddr_a = pos_r;
      end
      default:  ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = k_r;
    wdata = init_word;
    unique case (ctl.wr)
      WR_NONE:  ;
      WR_SEED: begin
        we    = 1'b1;
        waddr = '0;
        wdata = val_r;
      end
      WR_INIT:  we = 1'b1;
      WR_TWIST: begin
        we    = 1'b1;
        wdata = twist_word;
      end
      WR_REQ: begin
        we    = ({1'b0, idx_r} < TABLE_LEN);
        waddr = idx_r;
        wdata = val_r;
      end
      default:  ;
    endcase
  end

  always_comb begin
    k_nxt = k_r;
    if (ctl.k_clr) begin
      k_nxt = '0;
    end else if (ctl.wr == WR_SEED) begin
      k_nxt = ADDR_W'(1);
    end else if (ctl.k_inc) begin
      k_nxt = k_next_addr;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (ctl.wr == WR_SEED) begin
      pos_nxt = '0;
    end else if (out_load) begin
      pos_nxt = (pos_r == LAST_ADDR) ? '0 : pos_r + 1'b1;
    end
  end

  always_comb begin
    hold_nxt = hold_r;
    if (ctl.wr == WR_SEED) begin
      hold_nxt = val_r;
    end else if (ctl.wr == WR_INIT) begin
      hold_nxt = init_word;
    end else if (ctl.ld_hold) begin
      hold_nxt = rdata_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      k_r   <= k_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      val_r <= in_seed_or_word;
      idx_r <= in_word_index;
    end
    if (ctl.mul) begin
      prod_r <= WORD_W'(hold_mixed * INIT_MULT);
    end
    if (out_load) begin
      out_data_r <= temper(rdata_a);
    end
    hold_r <= hold_nxt;
  end

  mt_ram #(
    .DEPTH (TABLE_WORDS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign out_valid        = out_valid_r;
  assign out_random_value = out_data_r;

  assign stat.in_valid = in_valid;
  assign stat.op       = op_r;
  assign stat.pos_nz   = (pos_r != '0);
  assign stat.k_last   = k_last;
  assign stat.out_busy = out_busy;

  `MT_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_r <= LAST_ADDR, "read position out of range")
  `MT_ASSERT_IMP(a_k_range, clk, rst_n, 1'b1, k_r <= LAST_ADDR, "index counter out of range")
  `MT_ASSERT_IMP(a_waddr_range, clk, rst_n, we, waddr <= LAST_ADDR, "table write out of range")
  `MT_ASSERT_NXT(a_pos_step, clk, rst_n, out_load && pos_r != LAST_ADDR,
                 pos_r == $past(pos_r) + 1'b1, "read position did not advance")

endmodule

FILE: rtl/mt_sequencer.sv
// microcode sequencer: step counter, control rom and jump conditions
// depends on mt_pkg
module mt_sequencer import mt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mt_stat_t stat,
  output mt_ctl_t  ctl
);

  localparam int PC_W = 5;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_REQ,
    C_OP_SEED,
    C_OP_WRITE,
    C_NOT_DRAW,
    C_POS_NZ,
    C_K_NOT_LAST,
    C_OUT_BUSY,
    C_NEVER
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    mt_ctl_t         ctl;
  } uword_t;

  localparam logic [PC_W-1:0] S_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] S_DEC_SEED  = 5'd1;
  localparam logic [PC_W-1:0] S_DEC_WRITE = 5'd2;
  localparam logic [PC_W-1:0] S_DEC_DRAW  = 5'd3;
  localparam logic [PC_W-1:0] S_DR_CHK    = 5'd4;
  localparam logic [PC_W-1:0] S_TW_PRE    = 5'd5;
  localparam logic [PC_W-1:0] S_TW_LDC    = 5'd6;
  localparam logic [PC_W-1:0] S_TW_RD     = 5'd7;
  localparam logic [PC_W-1:0] S_TW_WR     = 5'd8;
  localparam logic [PC_W-1:0] S_FETCH     = 5'd9;
  localparam logic [PC_W-1:0] S_OUT       = 5'd10;
  localparam logic [PC_W-1:0] S_DONE      = 5'd11;
  localparam logic [PC_W-1:0] S_WRITE     = 5'd12;
  localparam logic [PC_W-1:0] S_SEED0     = 5'd13;
  localparam logic [PC_W-1:0] S_SD_MUL    = 5'd14;
  localparam logic [PC_W-1:0] S_SD_WR     = 5'd15;
  localparam logic [PC_W-1:0] S_SD_DONE   = 5'd16;

  function automatic uword_t rom(input logic [PC_W-1:0] pc);
    uword_t u;
    u        = '0;
    u.cond   = C_NEVER;
    u.target = S_IDLE;
    unique case (pc)
      S_IDLE: begin
        u.cond         = C_NO_REQ;
        u.target       = S_IDLE;
        u.ctl.in_ready = 1'b1;
      end
      S_DEC_SEED: begin
        u.cond   = C_OP_SEED;
        u.target = S_SEED0;
      end
      S_DEC_WRITE: begin
        u.cond   = C_OP_WRITE;
        u.target = S_WRITE;
      end
      S_DEC_DRAW: begin
        u.cond   = C_NOT_DRAW;
        u.target = S_IDLE;
      end
      S_DR_CHK: begin
        u.cond      = C_POS_NZ;
        u.target    = S_FETCH;
        u.ctl.k_clr = 1'b1;
      end
      S_TW_PRE: u.ctl.rd = RD_K;
      S_TW_LDC: u.ctl.ld_hold = 1'b1;
      S_TW_RD:  u.ctl.rd = RD_TWIST;
      S_TW_WR: begin
        u.cond        = C_K_NOT_LAST;
        u.target      = S_TW_RD;
        u.ctl.wr      = WR_TWIST;
        u.ctl.ld_hold = 1'b1;
        u.ctl.k_inc   = 1'b1;
      end
      S_FETCH: u.ctl.rd = RD_POS;
      S_OUT: begin
        u.cond       = C_OUT_BUSY;
        u.target     = S_OUT;
        u.ctl.ld_out = 1'b1;
      end
      S_DONE: begin
        u.cond   = C_ALWAYS;
        u.target = S_IDLE;
      end
      S_WRITE: begin
        u.cond   = C_ALWAYS;
        u.target = S_IDLE;
        u.ctl.wr = WR_REQ;
      end
      S_SEED0:  u.ctl.wr = WR_SEED;
      S_SD_MUL: u.ctl.mul = 1'b1;
      S_SD_WR: begin
        u.cond      = C_K_NOT_LAST;
        u.target    = S_SD_MUL;
        u.ctl.wr    = WR_INIT;
        u.ctl.k_inc = 1'b1;
      end
      S_SD_DONE: begin
        u.cond   = C_ALWAYS;
        u.target = S_IDLE;
      end
      default: begin
        u.cond   = C_ALWAYS;
        u.target = S_IDLE;
      end
    endcase
    return u;
  endfunction

  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            take;

  assign uw  = rom(pc_r);
  assign ctl = uw.ctl;

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:     take = 1'b1;
      C_NO_REQ:     take = ~stat.in_valid;
      C_OP_SEED:    take = (stat.op == OP_SEED);
      C_OP_WRITE:   take = (stat.op == OP_WRITE);
      C_NOT_DRAW:   take = (stat.op != OP_DRAW);
      C_POS_NZ:     take = stat.pos_nz;
      C_K_NOT_LAST: take = ~stat.k_last;
      C_OUT_BUSY:   take = stat.out_busy;
      C_NEVER:      take = 1'b0;
      default:      take = 1'b0;
    endcase
  end

  assign pc_nxt = take ? uw.target : pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/mersenne_twister_prng.sv
// top level of the mt19937 generator: sequencer plus datapath
// depends on mt_pkg, mt_if, mt_sequencer and mt_datapath
//
// usage: requests arrive on in_ch (valid/ready): op seed, draw or write one
// state word at word_index. each draw gives one word on out_ch; seed and write
// give nothing. one request is worked at a time; in_ch.ready is high only when
// the sequencer is idle.
// a seed takes two steps per table word (multiply, then add and store); a draw
// first regenerates the table when the read position is 0 (two steps per word
// through the dual-read table).
// the draw result sits in an output register, so the next request is accepted
// while it waits; a following draw stalls at its output step until out_ch takes
// the earlier word.
// reset clears the read position, the sequencer and the output valid; the
// state table is left as is and must be seeded before the first draw.
module mersenne_twister_prng import mt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mt_in_if.sink    in_ch,
  mt_out_if.source out_ch
);

  mt_ctl_t  ctl;
  mt_stat_t stat;

  assign in_ch.ready = ctl.in_ready;

  mt_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  mt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_valid         (in_ch.valid),
    .in_op            (in_ch.op),
    .in_seed_or_word  (in_ch.seed_or_word),
    .in_word_index    (in_ch.word_index),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_random_value (out_ch.random_value),
    .stat             (stat)
  );

endmodule

FILE: verif/tb_top.sv
// self-checking bench for the mt19937 generator: directed table, then random phases
// a predictor in this file holds its own copy of the state table and read position
// depends on mt_pkg, mt_if and mersenne_twister_prng
module tb_top import mt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 1300;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] val;
    logic [ADDR_W-1:0] idx;
    bit                known;
    logic [WORD_W-1:0] value;
  } req_row_t;

  localparam req_row_t DIRECTED_ROWS [24] = '{
    '{OP_WRITE, 32'hffffffff, 10'd0,   1'b0, 32'h0},
    '{OP_NOP,   32'hffffffff, 10'h3ff, 1'b0, 32'h0},
    '{OP_SEED,  32'd5489,     10'd0,   1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b1, 32'd3499211612},
    '{OP_DRAW,  32'h0,        10'd0,   1'b1, 32'd581869302},
    '{OP_DRAW,  32'h0,        10'd0,   1'b1, 32'd3890346734},
    '{OP_SEED,  32'd1,        10'd0,   1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b1, 32'd1791095845},
    '{OP_SEED,  32'h0,        10'd0,   1'b0, 32'h0},
    '{OP_DRAW,  32'hffffffff, 10'h3ff, 1'b0, 32'h0},
    '{OP_SEED,  32'hffffffff, 10'h3ff, 1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b0, 32'h0},
    '{OP_WRITE, 32'hffffffff, 10'd623, 1'b0, 32'h0},
    '{OP_WRITE, 32'h0,        10'd1,   1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b1, 32'h0},
    '{OP_WRITE, 32'hdeadbeef, 10'h3ff, 1'b0, 32'h0},
    '{OP_WRITE, 32'h12345678, 10'd624, 1'b0, 32'h0},
    '{OP_NOP,   32'h0,        10'd0,   1'b0, 32'h0},
    '{OP_WRITE, 32'hffffffff, 10'd2,   1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b0, 32'h0},
    '{OP_WRITE, 32'h80000000, 10'd3,   1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b0, 32'h0},
    '{OP_WRITE, 32'h00000001, 10'd4,   1'b0, 32'h0},
    '{OP_DRAW,  32'h0,        10'd0,   1'b0, 32'h0}
  };

  logic clk;
  logic rst_n;

  mt_in_if  in_ch ();
  mt_out_if out_ch ();

  mersenne_twister_prng dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [WORD_W-1:0] mt_words [TABLE_WORDS];
  int unsigned       mt_pos;
  bit                saw_wrap;
  logic [WORD_W-1:0] pending_values [$];
  int                error_count;
  int                src_gap_pct;
  int                sink_stall_pct;
  int                hold_reqs;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void seed_words(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] p;
    mt_words[0] = s;
    for (int k = 1; k < TABLE_WORDS; k++) begin
      p = mt_words[k-1];
      mt_words[k] = INIT_MULT * (p ^ (p >> 30)) + WORD_W'(k);
    end
    mt_pos = 0;
  endfunction

  function automatic void twist_words();
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] v;
    for (int k = 0; k < TABLE_WORDS; k++) begin
      mix = (mt_words[k] & UPPER_BIT) | (mt_words[(k + 1) % TABLE_WORDS] & LOWER_BITS);
      v = mt_words[(k + SHIFT_DIST) % TABLE_WORDS] ^ (mix >> 1);
      if (mix[0]) v = v ^ TWIST_XOR;
      mt_words[k] = v;
    end
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

  function automatic bit apply_request(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] val,
                                       input logic [ADDR_W-1:0] idx,
                                       output logic [WORD_W-1:0] value);
    value = '0;
    if (op == OP_SEED) begin
      seed_words(val);
      return 1'b0;
    end
    if (op == OP_WRITE) begin
      if (idx < TABLE_WORDS) mt_words[idx] = val;
      return 1'b0;
    end
    if (op == OP_DRAW) begin
      if (mt_pos == 0) twist_words();
      value = temper(mt_words[mt_pos]);
      mt_pos = (mt_pos + 1) % TABLE_WORDS;
      if (mt_pos == 0) saw_wrap = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val,
                              input logic [ADDR_W-1:0] idx, input bit known,
                              input logic [WORD_W-1:0] known_value);
    logic [WORD_W-1:0] value;
    bit has_value;
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.seed_or_word <= val;
    in_ch.word_index   <= idx;
    do @(posedge clk); while (!in_ch.ready);
    has_value = apply_request(op, val, idx, value);
    if (has_value) pending_values.push_back(known ? known_value : value);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int n, input bit until_wrap);
    int done;
    int r;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] v;
    logic [ADDR_W-1:0] ix;
    bit ignored;
    done = 0;
    while (done < n || (until_wrap && !saw_wrap)) begin
      r  = $urandom_range(999);
      v  = $urandom();
      ix = ADDR_W'($urandom());
      if (r < 62) begin
        op = OP_WRITE;
        if ($urandom_range(7) == 0) ix = ADDR_W'($urandom_range(1023, TABLE_WORDS));
        else ix = ADDR_W'($urandom_range(TABLE_WORDS - 1));
      end else if (r < 82) begin
        op = OP_NOP;
      end else begin
        op = OP_DRAW;
      end
      ignored = (op == OP_NOP) || (op == OP_WRITE && ix >= TABLE_WORDS);
      send_request(op, v, ix, 1'b0, '0);
      if (!ignored) done++;
    end
  endtask

  // result side: checks and ready pattern, with long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    logic [WORD_W-1:0] want;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_values.size() == 0) begin
          $error("random_value: expected none, actual %h", out_ch.random_value);
          error_count++;
        end else begin
          want = pending_values.pop_front();
          if (out_ch.random_value !== want) begin
            $error("random_value: expected %h, actual %h", want, out_ch.random_value);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    error_count    = 0;
    saw_wrap       = 1'b0;
    mt_pos         = 0;
    hold_reqs      = 0;
    src_gap_pct    = 7;
    sink_stall_pct = 71;
    for (int k = 0; k < TABLE_WORDS; k++) mt_words[k] = '0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_NOP;
    in_ch.seed_or_word <= '0;
    in_ch.word_index   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].idx,
                   DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].value);
    wait_drained();

    // one random seed, then a random mix of draws, writes and no-ops
    send_request(OP_SEED, $urandom(), '0, 1'b0, '0);
    send_random(250, 1'b0);
    wait_drained();

    src_gap_pct    = 71;
    sink_stall_pct = 7;
    send_random(250, 1'b0);
    wait_drained();

    // back-to-back requests while the result side holds off
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    hold_reqs <= hold_reqs + 1;
    send_random(240, 1'b1);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
